// File: design/vsp_pkg.sv
// Shared types, constants and register indexes for the silhouette projection vote block.
// No dependencies; every other design file refers to it by scoped names.
package vsp_pkg;

  localparam int IMG_ROWS = 512;
  localparam int IMG_COLS = 512;
  localparam int GRID_X   = 64;
  localparam int GRID_Y   = 64;
  localparam int GRID_Z   = 64;

  localparam int ROW_W      = 9;
  localparam int COL_W      = 9;
  localparam int VOX_W      = 6;
  localparam int SIL_AW     = 18;
  localparam int VOTE_AW    = 18;
  localparam int SIL_DEPTH  = IMG_ROWS * IMG_COLS;
  localparam int VOTE_DEPTH = GRID_X * GRID_Y * GRID_Z;

  localparam int COEF_W = 32;
  localparam int W_W    = 17;
  localparam int PROD_W = 49;
  localparam int NUM_W  = 50;
  localparam int MAG_W  = 49;
  localparam int Q_W    = 32;

  localparam int QD  = 4;
  localparam int QAW = 2;

  localparam int CFG_IW = 3;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_VOTE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [7:0] PIX_OBJECT = 8'd255;

  localparam logic [CFG_IW-1:0] CFG_R0A    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_R0B    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_R1A    = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_R1B    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_R2A    = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_R2B    = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN = 3'd6;

  typedef struct packed {
    logic [1:0]       op;
    logic [ROW_W-1:0] pix_row;
    logic [COL_W-1:0] pix_col;
    logic [7:0]       pix_value;
    logic [VOX_W-1:0] vox_x;
    logic [VOX_W-1:0] vox_y;
    logic [VOX_W-1:0] vox_z;
  } vsp_in_t;

  typedef struct packed {
    logic                  hit;
    logic [7:0]            vote_count;
    logic signed [Q_W-1:0] proj_col;
    logic signed [Q_W-1:0] proj_row;
  } vsp_out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               in_grid;
    logic [VOTE_AW-1:0] vote_addr;
    logic               sil_wr_ok;
    logic [SIL_AW-1:0]  sil_addr;
    logic               sil_set;
  } vsp_tag_t;

  typedef struct packed {
    vsp_tag_t              tag;
    logic signed [W_W-1:0] w0;
    logic signed [W_W-1:0] w1;
    logic signed [W_W-1:0] w2;
  } vsp_item_t;

  typedef struct packed {
    logic [5:0][63:0] coef;
  } vsp_cfg_t;

  typedef struct packed {
    vsp_tag_t             tag;
    logic [MAG_W-1:0]     remc;
    logic [MAG_W-1:0]     remr;
    logic [MAG_W-1:0]     nc;
    logic [MAG_W-1:0]     nr;
    logic [MAG_W-1:0]     qc;
    logic [MAG_W-1:0]     qr;
    logic [MAG_W-1:0]     d;
    logic                 negc;
    logic                 negr;
    logic                 dz;
  } vsp_div_t;

  typedef struct packed {
    vsp_tag_t              tag;
    logic                  in_img;
    logic [SIL_AW-1:0]     sil_rd_addr;
    logic signed [Q_W-1:0] pc;
    logic signed [Q_W-1:0] pr;
  } vsp_proj_t;

endpackage

// File: design/vsp_front.sv
// Front end: configuration registers, word decode and a short queue towards the back end.
// Depends on vsp_pkg.
module vsp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vsp_pkg::vsp_in_t           in_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vsp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_wdata,
  input  logic                       clearing,
  input  logic                       pop,
  output logic                       head_v,
  output vsp_pkg::vsp_item_t         head,
  output vsp_pkg::vsp_cfg_t          cfg
);

  logic [5:0][63:0]        coef_r;
  logic [47:0]             origin_r;
  logic [vsp_pkg::QAW:0]   wr_ptr_r;
  logic [vsp_pkg::QAW:0]   rd_ptr_r;
  vsp_pkg::vsp_item_t      q_r [vsp_pkg::QD];
  vsp_pkg::vsp_item_t      item;
  logic                    full;
  logic                    push;
  logic [vsp_pkg::VOX_W-1:0] zl;

  assign cfg_ready = 1'b1;
  assign cfg.coef  = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      origin_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vsp_pkg::CFG_R0A:    coef_r[0] <= cfg_wdata;
        vsp_pkg::CFG_R0B:    coef_r[1] <= cfg_wdata;
        vsp_pkg::CFG_R1A:    coef_r[2] <= cfg_wdata;
        vsp_pkg::CFG_R1B:    coef_r[3] <= cfg_wdata;
        vsp_pkg::CFG_R2A:    coef_r[4] <= cfg_wdata;
        vsp_pkg::CFG_R2B:    coef_r[5] <= cfg_wdata;
        vsp_pkg::CFG_ORIGIN: origin_r  <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    zl = vsp_pkg::VOX_W'(vsp_pkg::GRID_Z - 1) - in_data.vox_z;
    item.tag.op      = in_data.op;
    item.tag.in_grid = (int'(in_data.vox_x) < vsp_pkg::GRID_X) &&
                       (int'(in_data.vox_y) < vsp_pkg::GRID_Y) &&
                       (int'(in_data.vox_z) < vsp_pkg::GRID_Z);
    item.tag.vote_addr = vsp_pkg::VOTE_AW'(
        (vsp_pkg::VOTE_AW'(zl) * vsp_pkg::VOTE_AW'(vsp_pkg::GRID_X)
         + vsp_pkg::VOTE_AW'(in_data.vox_x)) * vsp_pkg::VOTE_AW'(vsp_pkg::GRID_Y)
        + vsp_pkg::VOTE_AW'(in_data.vox_y));
    item.tag.sil_wr_ok = (int'(in_data.pix_row) < vsp_pkg::IMG_ROWS) &&
                         (int'(in_data.pix_col) < vsp_pkg::IMG_COLS);
    item.tag.sil_addr = vsp_pkg::SIL_AW'(
        vsp_pkg::SIL_AW'(in_data.pix_row) * vsp_pkg::SIL_AW'(vsp_pkg::IMG_COLS)
        + vsp_pkg::SIL_AW'(in_data.pix_col));
    item.tag.sil_set = (in_data.pix_value == vsp_pkg::PIX_OBJECT);
    item.w0 = vsp_pkg::W_W'($signed(origin_r[47:32])) + $signed(vsp_pkg::W_W'(in_data.vox_x));
    item.w1 = vsp_pkg::W_W'($signed(origin_r[31:16])) + $signed(vsp_pkg::W_W'(in_data.vox_y));
    item.w2 = vsp_pkg::W_W'($signed(origin_r[15:0]))  + $signed(vsp_pkg::W_W'(in_data.vox_z));
  end

  assign full = (wr_ptr_r[vsp_pkg::QAW] != rd_ptr_r[vsp_pkg::QAW]) &&
                (wr_ptr_r[vsp_pkg::QAW-1:0] == rd_ptr_r[vsp_pkg::QAW-1:0]);
  assign head_v   = (wr_ptr_r != rd_ptr_r);
  assign in_ready = !full && !clearing;
  assign push     = in_valid && in_ready;
  assign head     = q_r[rd_ptr_r[vsp_pkg::QAW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r[vsp_pkg::QAW-1:0]] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: design/vsp_proj.sv
// Projection pipeline: products, sums, magnitudes, one quotient bit per stage, saturation.
// Depends on vsp_pkg.
module vsp_proj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                pop,
  input  vsp_pkg::vsp_item_t  head,
  input  vsp_pkg::vsp_cfg_t   cfg,
  output logic                out_v,
  output vsp_pkg::vsp_proj_t  out_p
);

  localparam int NS = vsp_pkg::MAG_W;

  function automatic logic signed [vsp_pkg::COEF_W-1:0] mat(vsp_pkg::vsp_cfg_t c, int r, int k);
    logic [63:0] word;
    word = c.coef[r * 2 + k / 2];
    return (k % 2 == 1) ? $signed(word[31:0]) : $signed(word[63:32]);
  endfunction

  function automatic vsp_pkg::vsp_div_t div_step(vsp_pkg::vsp_div_t s);
    vsp_pkg::vsp_div_t       o;
    logic [vsp_pkg::MAG_W:0] tc;
    logic [vsp_pkg::MAG_W:0] tr;
    logic [vsp_pkg::MAG_W:0] dd;
    o  = s;
    dd = {1'b0, s.d};
    tc = {s.remc, s.nc[vsp_pkg::MAG_W-1]};
    tr = {s.remr, s.nr[vsp_pkg::MAG_W-1]};
    if (tc >= dd) begin
      o.remc = vsp_pkg::MAG_W'(tc - dd);
      o.qc   = {s.qc[vsp_pkg::MAG_W-2:0], 1'b1};
    end else begin
      o.remc = tc[vsp_pkg::MAG_W-1:0];
      o.qc   = {s.qc[vsp_pkg::MAG_W-2:0], 1'b0};
    end
    if (tr >= dd) begin
      o.remr = vsp_pkg::MAG_W'(tr - dd);
      o.qr   = {s.qr[vsp_pkg::MAG_W-2:0], 1'b1};
    end else begin
      o.remr = tr[vsp_pkg::MAG_W-1:0];
      o.qr   = {s.qr[vsp_pkg::MAG_W-2:0], 1'b0};
    end
    o.nc = {s.nc[vsp_pkg::MAG_W-2:0], 1'b0};
    o.nr = {s.nr[vsp_pkg::MAG_W-2:0], 1'b0};
    return o;
  endfunction

  function automatic logic signed [vsp_pkg::Q_W-1:0] sgn_sat(logic [vsp_pkg::MAG_W-1:0] q,
                                                           logic neg);
    logic signed [vsp_pkg::MAG_W:0] sq;
    logic [vsp_pkg::MAG_W-vsp_pkg::Q_W+1:0] hi;
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    hi = sq[vsp_pkg::MAG_W:vsp_pkg::Q_W-1];
    if (hi == '0 || hi == '1) begin
      return sq[vsp_pkg::Q_W-1:0];
    end
    return sq[vsp_pkg::MAG_W] ? {1'b1, {(vsp_pkg::Q_W-1){1'b0}}}
                              : {1'b0, {(vsp_pkg::Q_W-1){1'b1}}};
  endfunction

  logic                                p0v_r;
  vsp_pkg::vsp_item_t                  p0_r;
  logic                                p1v_r;
  vsp_pkg::vsp_tag_t                   p1_tag_r;
  logic signed [vsp_pkg::PROD_W-1:0]   prod_r [3][3];
  logic signed [vsp_pkg::COEF_W-1:0]   m3_r [3];
  logic                                p2v_r;
  vsp_pkg::vsp_tag_t                   p2_tag_r;
  logic signed [vsp_pkg::NUM_W-1:0]    num_r [3];
  logic                                dvv_r [NS+1];
  vsp_pkg::vsp_div_t                   dv_r  [NS+1];
  logic                                p4v_r;
  vsp_pkg::vsp_proj_t                  p4_r;
  vsp_pkg::vsp_div_t                   dl;
  vsp_pkg::vsp_proj_t                  p4_nxt;
  logic signed [vsp_pkg::NUM_W-1:0]    ab [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= head;
      p1_tag_r <= p0_r.tag;
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= vsp_pkg::PROD_W'(mat(cfg, r, 0) * p0_r.w0);
        prod_r[r][1] <= vsp_pkg::PROD_W'(mat(cfg, r, 1) * p0_r.w1);
        prod_r[r][2] <= vsp_pkg::PROD_W'(mat(cfg, r, 2) * p0_r.w2);
        m3_r[r]      <= mat(cfg, r, 3);
      end
      p2_tag_r <= p1_tag_r;
      for (int r = 0; r < 3; r++) begin
        num_r[r] <= vsp_pkg::NUM_W'(prod_r[r][0]) + vsp_pkg::NUM_W'(prod_r[r][1])
                  + vsp_pkg::NUM_W'(prod_r[r][2]) + vsp_pkg::NUM_W'(m3_r[r]);
      end
      dv_r[0].tag  <= p2_tag_r;
      dv_r[0].remc <= '0;
      dv_r[0].remr <= '0;
      dv_r[0].qc   <= '0;
      dv_r[0].qr   <= '0;
      dv_r[0].nc   <= ab[0][vsp_pkg::MAG_W-1:0];
      dv_r[0].nr   <= ab[1][vsp_pkg::MAG_W-1:0];
      dv_r[0].d    <= ab[2][vsp_pkg::MAG_W-1:0];
      dv_r[0].negc <= num_r[0][vsp_pkg::NUM_W-1] ^ num_r[2][vsp_pkg::NUM_W-1];
      dv_r[0].negr <= num_r[1][vsp_pkg::NUM_W-1] ^ num_r[2][vsp_pkg::NUM_W-1];
      dv_r[0].dz   <= (num_r[2] == '0);
      for (int k = 0; k < NS; k++) begin
        dv_r[k+1] <= div_step(dv_r[k]);
      end
      p4_r <= p4_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ab[r] = num_r[r][vsp_pkg::NUM_W-1] ? -num_r[r] : num_r[r];
    end
  end

  always_comb begin
    dl         = dv_r[NS];
    p4_nxt.tag = dl.tag;
    if (dl.dz) begin
      p4_nxt.pc = '0;
      p4_nxt.pr = '0;
    end else begin
      p4_nxt.pc = sgn_sat(dl.qc, dl.negc);
      p4_nxt.pr = sgn_sat(dl.qr, dl.negr);
    end
    p4_nxt.in_img = !dl.dz && !p4_nxt.pc[vsp_pkg::Q_W-1] && !p4_nxt.pr[vsp_pkg::Q_W-1] &&
                    (p4_nxt.pc < vsp_pkg::Q_W'(vsp_pkg::IMG_COLS)) &&
                    (p4_nxt.pr < vsp_pkg::Q_W'(vsp_pkg::IMG_ROWS));
    p4_nxt.sil_rd_addr = vsp_pkg::SIL_AW'(
        vsp_pkg::SIL_AW'(p4_nxt.pr[vsp_pkg::ROW_W-1:0]) * vsp_pkg::SIL_AW'(vsp_pkg::IMG_COLS)
        + vsp_pkg::SIL_AW'(p4_nxt.pc[vsp_pkg::COL_W-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0v_r <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      p4v_r <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        dvv_r[k] <= 1'b0;
      end
    end else if (en) begin
      p0v_r    <= pop;
      p1v_r    <= p0v_r;
      p2v_r    <= p1v_r;
      dvv_r[0] <= p2v_r;
      for (int k = 0; k < NS; k++) begin
        dvv_r[k+1] <= dvv_r[k];
      end
      p4v_r <= dvv_r[NS];
    end
  end

  assign out_v = p4v_r;
  assign out_p = p4_r;

endmodule

// File: design/vsp_mem.sv
// Back end storage: silhouette bits, vote store read-modify-write and the vote clearing pass.
// Depends on vsp_pkg.
module vsp_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  vsp_pkg::vsp_proj_t in_p,
  output logic               out_v,
  output vsp_pkg::vsp_out_t  out_d,
  output logic               clearing
);

  logic                         sil_mem  [vsp_pkg::SIL_DEPTH];
  logic [7:0]                   vote_mem [vsp_pkg::VOTE_DEPTH];
  logic                         sil_rd_r;
  logic [7:0]                   vote_rd_r;
  logic                         s1v_r;
  vsp_pkg::vsp_proj_t           s1_r;
  logic                         clearing_r;
  logic [vsp_pkg::VOTE_AW-1:0]  clr_cnt_r;
  logic                         lw_v_r;
  logic [vsp_pkg::VOTE_AW-1:0]  lw_a_r;
  logic [7:0]                   lw_d_r;
  logic [7:0]                   cur;
  logic [7:0]                   newv;
  logic                         hit;
  logic                         is_vote;
  logic                         item_we;
  logic                         vote_we;
  logic [vsp_pkg::VOTE_AW-1:0]  vote_wa;
  logic [7:0]                   vote_wd;

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_v && in_p.tag.op == vsp_pkg::OP_LOAD && in_p.tag.sil_wr_ok) begin
        sil_mem[in_p.tag.sil_addr] <= in_p.tag.sil_set;
      end
      sil_rd_r <= sil_mem[in_p.sil_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vote_we) begin
      vote_mem[vote_wa] <= vote_wd;
    end
    if (en) begin
      vote_rd_r <= vote_mem[in_p.tag.vote_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_p;
    end
  end

  always_comb begin
    is_vote = (s1_r.tag.op == vsp_pkg::OP_VOTE);
    cur     = (lw_v_r && lw_a_r == s1_r.tag.vote_addr) ? lw_d_r : vote_rd_r;
    hit     = is_vote && s1_r.in_img && sil_rd_r;
    newv    = cur + 8'(hit);
    item_we = en && s1v_r && hit && s1_r.tag.in_grid;
    vote_we = clearing_r || item_we;
    vote_wa = clearing_r ? clr_cnt_r : s1_r.tag.vote_addr;
    vote_wd = clearing_r ? 8'd0 : newv;
    out_d.hit = hit;
    if (!s1_r.tag.in_grid) begin
      out_d.vote_count = 8'd0;
    end else if (is_vote) begin
      out_d.vote_count = newv;
    end else if (s1_r.tag.op == vsp_pkg::OP_READ) begin
      out_d.vote_count = cur;
    end else begin
      out_d.vote_count = 8'd0;
    end
    out_d.proj_col = is_vote ? s1_r.pc : '0;
    out_d.proj_row = is_vote ? s1_r.pr : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r      <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      lw_v_r     <= 1'b0;
    end else begin
      if (en) begin
        s1v_r <= in_v;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == vsp_pkg::VOTE_AW'(vsp_pkg::VOTE_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (item_we) begin
        lw_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      lw_a_r <= s1_r.tag.vote_addr;
      lw_d_r <= newv;
    end
  end

  assign out_v    = s1v_r;
  assign clearing = clearing_r;

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_v && !s1v_r)
    else $error("item reached vote store during clearing pass");

  a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !item_we)
    else $error("vote update collided with clearing pass");

  a_clear_ends_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_cnt_r) == vsp_pkg::VOTE_AW'(vsp_pkg::VOTE_DEPTH - 1))
    else $error("clearing pass ended early");

endmodule

// File: design/voxel_silhouette_projection_vote.sv
// Top level of the silhouette projection vote block.
// Depends on vsp_pkg, vsp_front, vsp_proj and vsp_mem.
// One word is accepted per cycle and one result word leaves per cycle while out_ready holds;
// a word passes from acceptance to the output register through the front queue, the projection
// pipeline (products, sums, 49 quotient-bit divider stages, saturation) and the vote store
// read-modify-write. After reset the vote store is cleared, one entry a cycle over all 262144
// entries, and in_ready stays low for that time; configuration writes are taken throughout.
module voxel_silhouette_projection_vote (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vsp_pkg::vsp_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vsp_pkg::vsp_out_t          out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vsp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [63:0]                cfg_wdata
);

  logic               en;
  logic               pop;
  logic               head_v;
  logic               clearing;
  vsp_pkg::vsp_item_t head;
  vsp_pkg::vsp_cfg_t  cfg;
  logic               pj_v;
  vsp_pkg::vsp_proj_t pj;
  logic               mem_v;
  vsp_pkg::vsp_out_t  mem_d;
  logic               out_valid_r;
  vsp_pkg::vsp_out_t  out_data_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_v;

  vsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .pop       (pop),
    .head_v    (head_v),
    .head      (head),
    .cfg       (cfg)
  );

  vsp_proj u_proj (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .pop   (pop),
    .head  (head),
    .cfg   (cfg),
    .out_v (pj_v),
    .out_p (pj)
  );

  vsp_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (pj_v),
    .in_p     (pj),
    .out_v    (mem_v),
    .out_d    (mem_d),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mem_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= mem_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
